[hdl/prp_pkg.sv]
`timescale 1ns / 1ps

package prp_pkg;

    // CORDIC datapath width: differences carry 61 bits after the guard shift,
    // plus growth from the CORDIC gain.
    localparam int CW = 64;
    localparam int HALF_W = CW / 2;

    // Angle accumulator: 2^32 units per turn, one extra bit of headroom.
    localparam int ZW = 33;

    localparam int ANG_W = 16;

    // Guard shift is this width less POS_WIDTH; the scaled difference carries one bit more in total.
    localparam int SCALED_W = 60;

    localparam int MAX_STEPS = 24;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_POS_WIDTH = 32;

    // 1/K for the CORDIC gain, Q0.32.
    localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

    // atan(2^-i) in 2^32 units per turn, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_turn(input int unsigned i);
        logic signed [ZW-1:0] r;
        case (i)
            0:       r = 33'sd536870912;
            1:       r = 33'sd316933406;
            2:       r = 33'sd167458907;
            3:       r = 33'sd85004756;
            4:       r = 33'sd42667331;
            5:       r = 33'sd21354465;
            6:       r = 33'sd10679838;
            7:       r = 33'sd5340245;
            8:       r = 33'sd2670163;
            9:       r = 33'sd1335087;
            10:      r = 33'sd667544;
            11:      r = 33'sd333772;
            12:      r = 33'sd166886;
            13:      r = 33'sd83443;
            14:      r = 33'sd41722;
            15:      r = 33'sd20861;
            16:      r = 33'sd10430;
            17:      r = 33'sd5215;
            18:      r = 33'sd2608;
            19:      r = 33'sd1304;
            20:      r = 33'sd652;
            21:      r = 33'sd326;
            22:      r = 33'sd163;
            23:      r = 33'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[hdl/prp_cordic.sv]
`timescale 1ns / 1ps

module prp_cordic
    import prp_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] in_x,
    input  logic signed [CW-1:0] in_y,
    input  logic signed [ZW-1:0] in_z,
    input  logic [ANG_W-1:0]     in_tag,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] out_x,
    output logic signed [CW-1:0] out_y,
    output logic [ANG_W-1:0]     out_tag
);

    logic                 v_reg   [CORDIC_STEPS];
    logic signed [CW-1:0] x_reg   [CORDIC_STEPS];
    logic signed [CW-1:0] y_reg   [CORDIC_STEPS];
    logic [ANG_W-1:0]     tag_reg [CORDIC_STEPS];
    // the last stage has no use for its angle
    logic signed [ZW-1:0] z_reg   [CORDIC_STEPS-1];
    logic                 rdy     [CORDIC_STEPS+1];

    assign rdy[CORDIC_STEPS] = out_ready;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
        logic                 v_in;
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic [ANG_W-1:0]     tag_in;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign x_in   = in_x;
            assign y_in   = in_y;
            assign z_in   = in_z;
            assign tag_in = in_tag;
        end else begin : g_rest
            assign v_in   = v_reg[k-1];
            assign x_in   = x_reg[k-1];
            assign y_in   = y_reg[k-1];
            assign z_in   = z_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        // stage holds while its item is waiting on a stalled successor
        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb begin
            if (z_in[ZW-1]) begin
                x_next = x_in + (y_in >>> k);
                y_next = y_in - (x_in >>> k);
            end else begin
                x_next = x_in - (y_in >>> k);
                y_next = y_in + (x_in >>> k);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && v_in) begin
                x_reg[k]   <= x_next;
                y_reg[k]   <= y_next;
                tag_reg[k] <= tag_in;
            end
        end

        if (k < CORDIC_STEPS - 1) begin : g_angle
            logic signed [ZW-1:0] z_next;

            always_comb begin
                if (z_in[ZW-1]) begin
                    z_next = z_in + atan_turn(k);
                end else begin
                    z_next = z_in - atan_turn(k);
                end
            end

            always_ff @(posedge aclk) begin
                if (rdy[k] && v_in) begin
                    z_reg[k] <= z_next;
                end
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STEPS-1];
    assign out_x     = x_reg[CORDIC_STEPS-1];
    assign out_y     = y_reg[CORDIC_STEPS-1];
    assign out_tag   = tag_reg[CORDIC_STEPS-1];

endmodule

[hdl/prp_gain.sv]
`timescale 1ns / 1ps

module prp_gain
    import prp_pkg::*;
#(
    parameter int POS_WIDTH = DEF_POS_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [CW-1:0]        in_x,
    input  logic signed [CW-1:0]        in_y,
    input  logic [ANG_W-1:0]            in_tag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [POS_WIDTH-1:0] out_x,
    output logic signed [POS_WIDTH-1:0] out_y,
    output logic [ANG_W-1:0]            out_tag
);

    localparam int GUARD = SCALED_W - POS_WIDTH;
    localparam logic signed [CW-1:0] RND    = CW'(1) <<< (GUARD - 1);
    localparam logic signed [CW-1:0] SAT_HI = (CW'(1) <<< (POS_WIDTH - 1)) - CW'(1);
    localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - CW'(1);

    // stage 1: partial products, stage 2: sum, stage 3: round and saturate
    logic                     v1_reg, v2_reg, v3_reg;
    logic                     rdy1, rdy2, rdy3;
    logic signed [CW-1:0]     phx_reg, phy_reg;
    logic [HALF_W-1:0]        plx_reg, ply_reg;
    logic [ANG_W-1:0]         tag1_reg, tag2_reg, tag3_reg;
    logic signed [CW-1:0]     gx_reg, gy_reg;
    logic signed [POS_WIDTH-1:0] ox_reg, oy_reg;

    logic signed [CW:0]       phx_full, phy_full;
    logic [CW-1:0]            plx_full, ply_full;
    logic signed [CW-1:0]     gx_next, gy_next;
    logic signed [POS_WIDTH-1:0] ox_next, oy_next;

    function automatic logic signed [POS_WIDTH-1:0] round_sat(input logic signed [CW-1:0] g);
        logic signed [CW-1:0] r;
        logic signed [POS_WIDTH-1:0] q;
        r = (g + RND) >>> GUARD;
        if (r > SAT_HI) begin
            q = SAT_HI[POS_WIDTH-1:0];
        end else if (r < SAT_LO) begin
            q = SAT_LO[POS_WIDTH-1:0];
        end else begin
            q = r[POS_WIDTH-1:0];
        end
        return q;
    endfunction

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // floor(x * gain) = hi * gain + floor(lo * gain / 2^32)
    always_comb begin
        phx_full = $signed(in_x[CW-1:HALF_W]) * $signed({1'b0, GAIN_Q32});
        phy_full = $signed(in_y[CW-1:HALF_W]) * $signed({1'b0, GAIN_Q32});
        plx_full = in_x[HALF_W-1:0] * GAIN_Q32;
        ply_full = in_y[HALF_W-1:0] * GAIN_Q32;
        gx_next  = phx_reg + $signed({{(CW-HALF_W){1'b0}}, plx_reg});
        gy_next  = phy_reg + $signed({{(CW-HALF_W){1'b0}}, ply_reg});
        ox_next  = round_sat(gx_reg);
        oy_next  = round_sat(gy_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            phx_reg  <= phx_full[CW-1:0];
            phy_reg  <= phy_full[CW-1:0];
            plx_reg  <= plx_full[CW-1:HALF_W];
            ply_reg  <= ply_full[CW-1:HALF_W];
            tag1_reg <= in_tag;
        end
        if (rdy2 && v1_reg) begin
            gx_reg   <= gx_next;
            gy_reg   <= gy_next;
            tag2_reg <= tag1_reg;
        end
        if (rdy3 && v2_reg) begin
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            tag3_reg <= tag2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_tag   = tag3_reg;

endmodule

[hdl/planar_relative_pose_top.sv]
`timescale 1ns / 1ps
// Planar relative pose: expresses a source pose in the frame of a reference pose.
// Input channel (s_*): one item is a reference pose and a source pose, each as
// x, y in signed Q16.16 and a 16-bit binary-angle heading. Result channel (m_*):
// rel_x, rel_y (difference rotated by minus the reference heading, rounded and
// saturated) and rel_heading (heading difference as a signed binary angle).
// Both channels are valid/ready; an item moves when valid and ready are high.
// Pipeline: a register for the difference and quadrant fold, one per CORDIC
// micro-rotation stage, then the gain registers for the multiply (split into
// 32-bit partial products), the partial-product sum and the round/saturate
// output register.
// Throughput: one item per cycle; every stage is its own register with a valid
// bit, so a new item enters each cycle while the pipeline flows.
// When the receiver stalls, results back up stage by stage; empty stages keep
// filling, and s_ready drops only once every stage holds an item. Nothing is
// lost or repeated. Synchronous reset (aresetn low) empties the pipeline;
// there is no other state.
module planar_relative_pose_top
    import prp_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
    parameter int POS_WIDTH    = DEF_POS_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [POS_WIDTH-1:0] s_ref_x,
    input  logic signed [POS_WIDTH-1:0] s_ref_y,
    input  logic [ANG_W-1:0]            s_ref_heading,
    input  logic signed [POS_WIDTH-1:0] s_src_x,
    input  logic signed [POS_WIDTH-1:0] s_src_y,
    input  logic [ANG_W-1:0]            s_src_heading,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [POS_WIDTH-1:0] m_rel_x,
    output logic signed [POS_WIDTH-1:0] m_rel_y,
    output logic signed [ANG_W-1:0]     m_rel_heading
);

    localparam int GUARD = SCALED_W - POS_WIDTH;
    localparam int XPAD  = CW - POS_WIDTH - 1 - GUARD;

    logic                      f_v_reg;
    logic signed [POS_WIDTH:0] f_dx_reg, f_dy_reg;
    logic [ANG_W-1:0]          f_s_reg;
    logic [ANG_W-1:0]          f_h_reg;

    logic                      f_rdy;
    logic [ANG_W-1:0]          rot;
    logic                      fold;
    logic signed [POS_WIDTH-1:0] a_x, b_x, a_y, b_y;
    logic signed [POS_WIDTH:0] dx_next, dy_next;
    logic [ANG_W-1:0]          s_next;

    logic signed [CW-1:0]      c_x, c_y;
    logic signed [ZW-1:0]      c_z;
    logic                      c_in_ready;
    logic                      c_out_valid, g_in_ready;
    logic signed [CW-1:0]      c_out_x, c_out_y;
    logic [ANG_W-1:0]          c_out_tag;
    logic [ANG_W-1:0]          g_out_tag;

    // rotation angle is minus the reference heading
    assign rot  = -s_ref_heading;
    // outside a quarter turn each way: negate the vector, move angle half a turn
    assign fold = rot[ANG_W-1] ^ rot[ANG_W-2];

    always_comb begin
        a_x     = fold ? s_ref_x : s_src_x;
        b_x     = fold ? s_src_x : s_ref_x;
        a_y     = fold ? s_ref_y : s_src_y;
        b_y     = fold ? s_src_y : s_ref_y;
        dx_next = {a_x[POS_WIDTH-1], a_x} - {b_x[POS_WIDTH-1], b_x};
        dy_next = {a_y[POS_WIDTH-1], a_y} - {b_y[POS_WIDTH-1], b_y};
        s_next  = {rot[ANG_W-1] ^ fold, rot[ANG_W-2:0]};
    end

    assign f_rdy   = !f_v_reg || c_in_ready;
    assign s_ready = f_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_v_reg <= 1'b0;
        end else if (f_rdy) begin
            f_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_rdy && s_valid) begin
            f_dx_reg <= dx_next;
            f_dy_reg <= dy_next;
            f_s_reg  <= s_next;
            f_h_reg  <= s_src_heading - s_ref_heading;
        end
    end

    // guard shift and angle scaling are wiring only
    assign c_x = {{XPAD{f_dx_reg[POS_WIDTH]}}, f_dx_reg, {GUARD{1'b0}}};
    assign c_y = {{XPAD{f_dy_reg[POS_WIDTH]}}, f_dy_reg, {GUARD{1'b0}}};
    assign c_z = {f_s_reg[ANG_W-1], f_s_reg, {(ZW-ANG_W-1){1'b0}}};

    prp_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_v_reg),
        .in_ready  (c_in_ready),
        .in_x      (c_x),
        .in_y      (c_y),
        .in_z      (c_z),
        .in_tag    (f_h_reg),
        .out_valid (c_out_valid),
        .out_ready (g_in_ready),
        .out_x     (c_out_x),
        .out_y     (c_out_y),
        .out_tag   (c_out_tag)
    );

    prp_gain #(
        .POS_WIDTH(POS_WIDTH)
    ) u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_out_valid),
        .in_ready  (g_in_ready),
        .in_x      (c_out_x),
        .in_y      (c_out_y),
        .in_tag    (c_out_tag),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_x     (m_rel_x),
        .out_y     (m_rel_y),
        .out_tag   (g_out_tag)
    );

    assign m_rel_heading = $signed(g_out_tag);

endmodule
